// ----- rtl/assert_macros.svh -----
// Assertion helpers, clocked on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked also while reset is high.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/pst_pkg.sv -----
`default_nettype none
package pst_pkg;

  localparam int SYMBOLS   = 256;
  localparam int IDX_W     = $clog2(SYMBOLS);
  localparam int SYM_W     = 8;
  localparam int TIME_W    = 48;
  localparam int QTY_W     = 20;
  localparam int PRICE_W   = 24;
  localparam int VOL_W     = 40;
  localparam int WSUM_W    = 56;
  localparam int PROD_W    = PRICE_W + QTY_W;
  localparam int DIV_STEPS = PRICE_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);
  localparam int DSR_W     = VOL_W + DIV_STEPS - 1;

  localparam logic [VOL_W-1:0]   VOL_MAX  = {VOL_W{1'b1}};
  localparam logic [WSUM_W-1:0]  WSUM_MAX = {WSUM_W{1'b1}};
  localparam logic [PRICE_W-1:0] AVG_MAX  = {PRICE_W{1'b1}};

  localparam logic ACT_TRADE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic               valid;
    logic [TIME_W-1:0]  last_time;
    logic [TIME_W-1:0]  gap_max;
    logic [VOL_W-1:0]   volume_sum;
    logic [WSUM_W-1:0]  weighted_sum;
    logic [PRICE_W-1:0] price_max;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic capture;
    logic clr_write;
    logic trade_write;
    logic div_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic hit;
    logic div_last;
    logic clr_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ----- rtl/per_symbol_trade_statistics_top.sv -----
// Per-symbol trade statistics table. After reset the table is cleared by a pass
// that writes each of the SYMBOLS (256) entries, during which in_ready stays low.
// Transactions are handled one at a time; each is a read-modify-write of one table
// entry in a single-port-write RAM with registered read. A trade passes through
// states S_RD and S_EVAL before the next acceptance and gives no result. A query of a
// symbol that has traded runs the 24-step restoring divider that forms the
// volume-weighted average price; a query of an unseen or out-of-table symbol
// skips the divider and returns all zeros. A result waits in the output register;
// the next transaction is still accepted, but a later query waits in S_FIN until it is taken.
`default_nettype none
`include "assert_macros.svh"
module per_symbol_trade_statistics_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        action,
  input  wire logic [pst_pkg::SYM_W-1:0]   symbol,
  input  wire logic [pst_pkg::TIME_W-1:0]  trade_time,
  input  wire logic [pst_pkg::QTY_W-1:0]   quantity,
  input  wire logic [pst_pkg::PRICE_W-1:0] price,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             seen,
  output logic      [pst_pkg::TIME_W-1:0]  largest_gap,
  output logic      [pst_pkg::VOL_W-1:0]   volume_total,
  output logic      [pst_pkg::PRICE_W-1:0] average_price,
  output logic      [pst_pkg::PRICE_W-1:0] top_price
);

  pst_pkg::cmd_t    cmd;
  pst_pkg::status_t st;

  pst_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .st      (st),
    .cmd     (cmd)
  );

  pst_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .action       (action),
    .symbol       (symbol),
    .trade_time   (trade_time),
    .quantity     (quantity),
    .price        (price),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .seen         (seen),
    .largest_gap  (largest_gap),
    .volume_total (volume_total),
    .average_price(average_price),
    .top_price    (top_price)
  );

  `ASSERT_CLK_ALWAYS(a_no_accept_after_rst, rst |=> !in_ready, "input ready right after reset")
  `ASSERT_CLK(a_one_at_a_time, (in_valid && in_ready) |=> !in_ready, "second transaction taken early")
  `ASSERT_CLK(a_result_from_load, $rose(out_valid) |-> $past(cmd.out_load), "result without query")
  `ASSERT_CLK(a_cmd_exclusive, $onehot0({cmd.capture, cmd.clr_write, cmd.trade_write, cmd.div_step, cmd.out_load}), "conflicting commands")

endmodule
`default_nettype wire

// ----- rtl/pst_ram.sv -----
`default_nettype none
module pst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/pst_ctrl.sv -----
`default_nettype none
module pst_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire pst_pkg::status_t st,
  output pst_pkg::cmd_t         cmd
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLR: begin
        cmd.clr_write = 1'b1;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_RD;
        end
      end
      S_RD: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (st.is_query) begin
          cmd.div_load = 1'b1;
          state_next   = st.hit ? S_DIV : S_FIN;
        end else begin
          cmd.trade_write = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_next = S_FIN;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLR;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/pst_datapath.sv -----
`default_nettype none
module pst_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire pst_pkg::cmd_t                 cmd,
  output pst_pkg::status_t                   st,
  input  wire logic                          action,
  input  wire logic [pst_pkg::SYM_W-1:0]     symbol,
  input  wire logic [pst_pkg::TIME_W-1:0]    trade_time,
  input  wire logic [pst_pkg::QTY_W-1:0]     quantity,
  input  wire logic [pst_pkg::PRICE_W-1:0]   price,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               seen,
  output logic      [pst_pkg::TIME_W-1:0]    largest_gap,
  output logic      [pst_pkg::VOL_W-1:0]     volume_total,
  output logic      [pst_pkg::PRICE_W-1:0]   average_price,
  output logic      [pst_pkg::PRICE_W-1:0]   top_price
);

  // captured transaction
  logic                          action_q;
  logic [pst_pkg::SYM_W-1:0]     sym_q;
  logic [pst_pkg::TIME_W-1:0]    time_q;
  logic [pst_pkg::QTY_W-1:0]     qty_q;
  logic [pst_pkg::PRICE_W-1:0]   price_q;
  logic [pst_pkg::PROD_W-1:0]    prod;

  logic [pst_pkg::IDX_W-1:0]     clr_cnt;
  logic [pst_pkg::IDX_W-1:0]     idx;
  logic                          in_range;

  logic                          ram_we;
  logic [pst_pkg::IDX_W-1:0]     ram_waddr;
  logic [pst_pkg::ENTRY_W-1:0]   ram_wdata;
  logic [pst_pkg::ENTRY_W-1:0]   ram_rdata;
  pst_pkg::entry_t               e;
  pst_pkg::entry_t               upd;

  logic [pst_pkg::TIME_W-1:0]    diff;
  logic [pst_pkg::VOL_W:0]       vol_add;
  logic [pst_pkg::WSUM_W:0]      ws_add;

  // divider and result hold
  logic [pst_pkg::WSUM_W-1:0]    rem;
  logic [pst_pkg::DSR_W-1:0]     dsr;
  logic [pst_pkg::PRICE_W-1:0]   quo;
  logic [pst_pkg::DCNT_W-1:0]    dcnt;
  logic                          ge;
  logic                          div_sat;
  logic                          div_zero;
  logic                          hit_h;
  logic [pst_pkg::TIME_W-1:0]    gap_h;
  logic [pst_pkg::VOL_W-1:0]     vol_h;
  logic [pst_pkg::PRICE_W-1:0]   pm_h;
  logic [pst_pkg::PRICE_W-1:0]   avg;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_q <= action;
      sym_q    <= symbol;
      time_q   <= trade_time;
      qty_q    <= quantity;
      price_q  <= price;
    end
    prod <= pst_pkg::PROD_W'(price_q) * pst_pkg::PROD_W'(qty_q);
  end

  assign idx      = pst_pkg::IDX_W'(sym_q);
  assign in_range = ({24'd0, sym_q} < 32'(pst_pkg::SYMBOLS));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_write) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign e = pst_pkg::entry_t'(ram_rdata);

  always_comb begin
    diff    = time_q - e.last_time;
    vol_add = {1'b0, e.volume_sum} + (pst_pkg::VOL_W+1)'(qty_q);
    ws_add  = {1'b0, e.weighted_sum} + (pst_pkg::WSUM_W+1)'(prod);
    upd.valid     = 1'b1;
    upd.last_time = time_q;
    if (!e.valid) begin
      upd.gap_max      = '0;
      upd.volume_sum   = pst_pkg::VOL_W'(qty_q);
      upd.weighted_sum = pst_pkg::WSUM_W'(prod);
      upd.price_max    = price_q;
    end else begin
      upd.gap_max = ((time_q >= e.last_time) && (diff > e.gap_max)) ? diff : e.gap_max;
      upd.volume_sum = vol_add[pst_pkg::VOL_W] ? pst_pkg::VOL_MAX
                                              : vol_add[pst_pkg::VOL_W-1:0];
      upd.weighted_sum = ws_add[pst_pkg::WSUM_W] ? pst_pkg::WSUM_MAX
                                                : ws_add[pst_pkg::WSUM_W-1:0];
      upd.price_max = (price_q > e.price_max) ? price_q : e.price_max;
    end
  end

  always_comb begin
    ram_we    = cmd.clr_write || (cmd.trade_write && in_range);
    ram_waddr = cmd.clr_write ? clr_cnt : idx;
    ram_wdata = cmd.clr_write ? '0 : pst_pkg::ENTRY_W'(upd);
  end

  pst_ram #(
    .WIDTH(pst_pkg::ENTRY_W),
    .DEPTH(pst_pkg::SYMBOLS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  // restoring divide, one quotient bit per cycle
  assign ge = (pst_pkg::DSR_W'(rem) >= dsr);

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem      <= e.weighted_sum;
      dsr      <= {e.volume_sum, {(pst_pkg::DIV_STEPS-1){1'b0}}};
      quo      <= '0;
      dcnt     <= '0;
      div_zero <= (e.volume_sum == '0);
      div_sat  <= ((pst_pkg::VOL_W+pst_pkg::DIV_STEPS)'(e.weighted_sum)
                   >= {e.volume_sum, {pst_pkg::DIV_STEPS{1'b0}}});
      hit_h    <= in_range && e.valid;
      gap_h    <= e.gap_max;
      vol_h    <= e.volume_sum;
      pm_h     <= e.price_max;
    end else if (cmd.div_step) begin
      if (ge) rem <= rem - dsr[pst_pkg::WSUM_W-1:0];
      dsr  <= dsr >> 1;
      quo  <= {quo[pst_pkg::PRICE_W-2:0], ge};
      dcnt <= dcnt + 1'b1;
    end
  end

  assign avg = div_zero ? '0 : (div_sat ? pst_pkg::AVG_MAX : quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      seen          <= hit_h;
      largest_gap   <= hit_h ? gap_h : '0;
      volume_total  <= hit_h ? vol_h : '0;
      average_price <= hit_h ? avg : '0;
      top_price     <= hit_h ? pm_h : '0;
    end
  end

  always_comb begin
    st.is_query = (action_q == pst_pkg::ACT_QUERY);
    st.hit      = in_range && e.valid;
    st.div_last = (dcnt == pst_pkg::DCNT_W'(pst_pkg::DIV_STEPS-1));
    st.clr_last = (clr_cnt == pst_pkg::IDX_W'(pst_pkg::SYMBOLS-1));
    st.out_free = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

// ----- dv/per_symbol_trade_statistics_top_tb.sv -----
`timescale 1ns / 100ps
module per_symbol_trade_statistics_top_tb;

  localparam int SYMBOLS = pst_pkg::SYMBOLS;
  localparam int SYM_W   = pst_pkg::SYM_W;
  localparam int TIME_W  = pst_pkg::TIME_W;
  localparam int QTY_W   = pst_pkg::QTY_W;
  localparam int PRICE_W = pst_pkg::PRICE_W;
  localparam int VOL_W   = pst_pkg::VOL_W;
  localparam int WSUM_W  = pst_pkg::WSUM_W;
  localparam int PROD_W  = pst_pkg::PROD_W;

  localparam logic [VOL_W-1:0]   VOL_MAX   = pst_pkg::VOL_MAX;
  localparam logic [WSUM_W-1:0]  WSUM_MAX  = pst_pkg::WSUM_MAX;
  localparam logic [PRICE_W-1:0] AVG_MAX   = pst_pkg::AVG_MAX;
  localparam logic               ACT_TRADE = pst_pkg::ACT_TRADE;
  localparam logic               ACT_QUERY = pst_pkg::ACT_QUERY;

  localparam int RAND_ITEMS   = 1560;
  localparam int SAT_TRADES   = 32;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 40;

  localparam logic [TIME_W-1:0]  TIME_MAX = {TIME_W{1'b1}};
  localparam logic [QTY_W-1:0]   QTY_MAX  = {QTY_W{1'b1}};
  localparam logic [PRICE_W-1:0] PX_MAX   = {PRICE_W{1'b1}};

  typedef struct packed {
    logic               seen;
    logic [TIME_W-1:0]  gap;
    logic [VOL_W-1:0]   vol;
    logic [PRICE_W-1:0] avg;
    logic [PRICE_W-1:0] top;
  } stats_t;

  typedef struct {
    logic               act;
    logic [SYM_W-1:0]   sym;
    logic [TIME_W-1:0]  stamp;
    logic [QTY_W-1:0]   qty;
    logic [PRICE_W-1:0] px;
    int                 reps;
    bit                 typed;
    stats_t             want;
  } stim_row_t;

  typedef enum {RDY_ALWAYS, RDY_HALF, RDY_MOSTLY, RDY_PATTERN} rdy_mode_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic                 action;
  logic [SYM_W-1:0]     symbol;
  logic [TIME_W-1:0]    trade_time;
  logic [QTY_W-1:0]     quantity;
  logic [PRICE_W-1:0]   price;
  logic                 out_valid;
  logic                 out_ready;
  logic                 seen;
  logic [TIME_W-1:0]    largest_gap;
  logic [VOL_W-1:0]     volume_total;
  logic [PRICE_W-1:0]   average_price;
  logic [PRICE_W-1:0]   top_price;

  // symbol table shadow
  logic                 sym_seen [SYMBOLS];
  logic [TIME_W-1:0]    sym_last [SYMBOLS];
  logic [TIME_W-1:0]    sym_gap  [SYMBOLS];
  logic [VOL_W-1:0]     sym_vol  [SYMBOLS];
  logic [WSUM_W-1:0]    sym_wsum [SYMBOLS];
  logic [PRICE_W-1:0]   sym_top  [SYMBOLS];

  stats_t               pending_stats[$];
  stim_row_t            steps[$];
  int                   mismatches;
  int                   burst_left;
  bit                   hold_go;
  bit                   hold_done;

  per_symbol_trade_statistics_top u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .symbol        (symbol),
    .trade_time    (trade_time),
    .quantity      (quantity),
    .price         (price),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .seen          (seen),
    .largest_gap   (largest_gap),
    .volume_total  (volume_total),
    .average_price (average_price),
    .top_price     (top_price)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic add_step(input stim_row_t row);
    steps.insert(steps.size(), row);
  endtask

  task automatic book_trade(input logic [SYM_W-1:0] sym, input logic [TIME_W-1:0] stamp,
                            input logic [QTY_W-1:0] qty, input logic [PRICE_W-1:0] px);
    logic [PROD_W-1:0] prod;
    logic [VOL_W:0]    vsum;
    logic [WSUM_W:0]   wsum;
    if (int'(sym) >= SYMBOLS) return;
    prod = PROD_W'(px) * PROD_W'(qty);
    if (!sym_seen[sym]) begin
      sym_seen[sym] = 1'b1;
      sym_last[sym] = stamp;
      sym_gap[sym]  = '0;
      sym_vol[sym]  = VOL_W'(qty);
      sym_wsum[sym] = WSUM_W'(prod);
      sym_top[sym]  = px;
      return;
    end
    // backward time step leaves the largest gap alone
    if (stamp >= sym_last[sym] && (stamp - sym_last[sym]) > sym_gap[sym])
      sym_gap[sym] = stamp - sym_last[sym];
    if (px > sym_top[sym]) sym_top[sym] = px;
    sym_last[sym] = stamp;
    vsum = {1'b0, sym_vol[sym]} + (VOL_W+1)'(qty);
    sym_vol[sym] = vsum[VOL_W] ? VOL_MAX : vsum[VOL_W-1:0];
    wsum = {1'b0, sym_wsum[sym]} + (WSUM_W+1)'(prod);
    sym_wsum[sym] = wsum[WSUM_W] ? WSUM_MAX : wsum[WSUM_W-1:0];
  endtask

  function automatic stats_t sym_stats(input logic [SYM_W-1:0] sym);
    stats_t            r;
    logic [WSUM_W-1:0] quo;
    r = '0;
    if (int'(sym) >= SYMBOLS || !sym_seen[sym]) return r;
    r.seen = 1'b1;
    r.gap  = sym_gap[sym];
    r.vol  = sym_vol[sym];
    r.top  = sym_top[sym];
    if (sym_vol[sym] != '0) begin
      quo   = sym_wsum[sym] / WSUM_W'(sym_vol[sym]);
      r.avg = (quo > WSUM_W'(AVG_MAX)) ? AVG_MAX : quo[PRICE_W-1:0];
    end
    return r;
  endfunction

  task automatic offer_txn(input logic act, input logic [SYM_W-1:0] sym,
                           input logic [TIME_W-1:0] stamp, input logic [QTY_W-1:0] qty,
                           input logic [PRICE_W-1:0] px, input bit typed, input stats_t want);
    int gap_len;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap_len > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap_len - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid   <= 1'b1;
    action     <= act;
    symbol     <= sym;
    trade_time <= stamp;
    quantity   <= qty;
    price      <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (act == ACT_TRADE) book_trade(sym, stamp, qty, px);
    else pending_stats.insert(pending_stats.size(), typed ? want : sym_stats(sym));
  endtask

  task automatic check_stat(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    stats_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_stats.size() == 0) begin
        $display("%0t: unexpected result transaction, actual seen %0h gap %0h vol %0h",
                 $time, seen, largest_gap, volume_total);
        mismatches++;
      end else begin
        want = pending_stats.pop_front();
        check_stat("seen", 64'(want.seen), 64'(seen));
        check_stat("largest_gap", 64'(want.gap), 64'(largest_gap));
        check_stat("volume_total", 64'(want.vol), 64'(volume_total));
        check_stat("average_price", 64'(want.avg), 64'(average_price));
        check_stat("top_price", 64'(want.top), 64'(top_price));
      end
    end
  end

  initial begin
    rdy_mode_t mode;
    int        left;
    int        cyc;
    out_ready = 1'b0;
    mode = RDY_ALWAYS;
    left = 0;
    cyc  = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_go && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        if (left == 0) begin
          mode = rdy_mode_t'($urandom_range(0, 3));
          left = $urandom_range(32, 256);
        end
        left--;
        case (mode)
          RDY_ALWAYS: out_ready <= 1'b1;
          RDY_HALF:   out_ready <= ($urandom_range(0, 1) == 1);
          RDY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
          default:    out_ready <= ((cyc % 5) < 2);
        endcase
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [SYM_W-1:0]   hot[8];
    logic               act;
    logic [SYM_W-1:0]   sym;
    logic [TIME_W-1:0]  stamp;
    logic [TIME_W-1:0]  now;
    logic [QTY_W-1:0]   qty;
    logic [PRICE_W-1:0] px;
    int                 i;
    int                 k;

    rst        = 1'b1;
    in_valid   = 1'b0;
    action     = ACT_TRADE;
    symbol     = '0;
    trade_time = '0;
    quantity   = '0;
    price      = '0;
    mismatches = 0;
    burst_left = 0;
    foreach (sym_seen[j]) begin
      sym_seen[j] = 1'b0;
      sym_last[j] = '0;
      sym_gap[j]  = '0;
      sym_vol[j]  = '0;
      sym_wsum[j] = '0;
      sym_top[j]  = '0;
    end

    // unseen symbols, zero volume, widest gap, extremes, backward time, repeated heavy trades
    add_step('{ACT_QUERY, 8'd0,   '0, '0, '0, 1, 1'b1, '0});
    add_step('{ACT_QUERY, 8'd255, '0, '0, '0, 1, 1'b1, '0});
    add_step('{ACT_TRADE, 8'd0,   '0, '0, '0, 1, 1'b0, '0});
    add_step('{ACT_QUERY, 8'd0,   '0, '0, '0, 1, 1'b1,
               '{1'b1, '0, '0, '0, '0}});
    add_step('{ACT_TRADE, 8'd0,   TIME_MAX, '0, '0, 1, 1'b0, '0});
    add_step('{ACT_QUERY, 8'd0,   '0, '0, '0, 1, 1'b1,
               '{1'b1, TIME_MAX, '0, '0, '0}});
    add_step('{ACT_TRADE, 8'd255, 48'd1000, QTY_MAX, PX_MAX, 1, 1'b0, '0});
    add_step('{ACT_QUERY, 8'd255, '0, '0, '0, 1, 1'b1,
               '{1'b1, '0, VOL_W'(QTY_MAX), PX_MAX, PX_MAX}});
    add_step('{ACT_TRADE, 8'd255, 48'd500, 20'd1, 24'd1, 1, 1'b0, '0});
    add_step('{ACT_TRADE, 8'd255, 48'd700, 20'd2, 24'd3, 1, 1'b0, '0});
    add_step('{ACT_QUERY, 8'd255, '0, '0, '0, 1, 1'b0, '0});
    add_step('{ACT_TRADE, 8'd17, 48'h8000_0000_0000, 20'd3, 24'd10, 1, 1'b0, '0});
    add_step('{ACT_TRADE, 8'd17, 48'h8000_0000_0005, 20'd7, 24'd20, 1, 1'b0, '0});
    add_step('{ACT_QUERY, 8'd17, TIME_MAX, QTY_MAX, PX_MAX, 1, 1'b0, '0});
    add_step('{ACT_TRADE, 8'd200, 48'h1000, QTY_MAX, PX_MAX, SAT_TRADES, 1'b0, '0});
    add_step('{ACT_QUERY, 8'd200, '0, '0, '0, 1, 1'b0, '0});
    add_step('{ACT_TRADE, 8'd200, 48'h2000, 20'd5, 24'd1, 1, 1'b0, '0});
    add_step('{ACT_QUERY, 8'd200, '0, '0, '0, 1, 1'b0, '0});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < steps.size(); i++)
      for (k = 0; k < steps[i].reps; k++)
        offer_txn(steps[i].act, steps[i].sym, steps[i].stamp + TIME_W'(k), steps[i].qty,
                  steps[i].px, steps[i].typed, steps[i].want);

    foreach (hot[j]) hot[j] = SYM_W'($urandom_range(0, 255));
    now = '0;
    for (i = 0; i < RAND_ITEMS; i++) begin
      if (i == HOLD_AT) hold_go = 1'b1;
      sym = ($urandom_range(0, 9) < 7) ? hot[$urandom_range(0, 7)]
                                       : SYM_W'($urandom_range(0, 255));
      act = ($urandom_range(0, 9) < 3) ? ACT_QUERY : ACT_TRADE;
      case ($urandom_range(0, 19))
        0: stamp = now - TIME_W'($urandom_range(1, 100000));
        1: stamp = TIME_W'({$urandom(), $urandom()});
        default: begin
          now   = now + TIME_W'($urandom_range(0, 5000));
          stamp = now;
        end
      endcase
      case ($urandom_range(0, 9))
        0:       qty = '0;
        1:       qty = QTY_MAX;
        2, 3, 4: qty = QTY_W'($urandom_range(1, 1000));
        default: qty = QTY_W'($urandom());
      endcase
      case ($urandom_range(0, 9))
        0:       px = '0;
        1:       px = PX_MAX;
        default: px = PRICE_W'($urandom());
      endcase
      offer_txn(act, sym, stamp, qty, px, 1'b0, '0);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/pst_pkg.sv
rtl/pst_ram.sv
rtl/pst_ctrl.sv
rtl/pst_datapath.sv
rtl/per_symbol_trade_statistics_top.sv
dv/per_symbol_trade_statistics_top_tb.sv
